FILE: sv/modbus_rtu_request_framer_macros.svh
// ----------------------------------------------------------------------------
// Modbus RTU request framer: assertion macros
// Concurrent checks sampled on i_clk and held off while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef MODBUS_RTU_REQUEST_FRAMER_MACROS_SVH
`define MODBUS_RTU_REQUEST_FRAMER_MACROS_SVH

// same-cycle implication
`define MRF_ASSERT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("mrf: check failed");

// next-cycle implication
`define MRF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("mrf: check failed");

`endif

FILE: sv/mrf_pkg.sv
// ----------------------------------------------------------------------------
// mrf_pkg
// Types, constants and the CRC16 byte update shared by the framer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package mrf_pkg;

    localparam int PLAN_SLOTS = 8;
    localparam int PLAN_IDX_W = $clog2(PLAN_SLOTS);

    localparam logic [6:0]  MAX_WRITE_WORDS = 7'd123;
    localparam logic [15:0] CRC_INIT        = 16'hFFFF;
    localparam logic [15:0] CRC_POLY        = 16'hA001;
    localparam logic [7:0]  SLAVE_ADDR_RST  = 8'd1;

    localparam int          CFG_ADDR_W      = 3;
    localparam logic [0:0]  REG_SLAVE_ADDR  = 1'b0;

    typedef enum logic [1:0] {
        MODE_READ       = 2'd0,
        MODE_WRITE_HDR  = 2'd1,
        MODE_WRITE_DATA = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        SLOT_DATA   = 2'd0,
        SLOT_CRC_LO = 2'd1,
        SLOT_CRC_HI = 2'd2
    } t_slot_kind;

    // Byte plan for one input word: up to eight frame bytes.
    typedef struct packed {
        logic       [PLAN_SLOTS-1:0][7:0] data;
        t_slot_kind [PLAN_SLOTS-1:0]      kind;
        logic                             head;
        logic       [PLAN_IDX_W-1:0]      last;
    } t_plan;

    // Modbus CRC16, reflected, one byte.
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: sv/mrf_ifs.sv
// ----------------------------------------------------------------------------
// mrf channel interfaces
// Request channel into the framer and byte channel out of it.
// ----------------------------------------------------------------------------
`default_nettype none

interface mrf_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [7:0]  function_code;
    logic [15:0] reg_address;
    logic [6:0]  reg_count;
    logic [15:0] data_word;

    modport source (output valid, mode, function_code, reg_address, reg_count, data_word,
                     input ready);
    modport sink   (input valid, mode, function_code, reg_address, reg_count, data_word,
                     output ready);
endinterface

interface mrf_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] tx_byte;
    logic       frame_start;
    logic       frame_end;
    logic       run_last;

    modport source (output valid, tx_byte, frame_start, frame_end, run_last, input ready);
    modport sink   (input valid, tx_byte, frame_start, frame_end, run_last, output ready);
endinterface

`default_nettype wire

FILE: sv/mrf_cfg.sv
// ----------------------------------------------------------------------------
// mrf_cfg
// APB register file: holds the slave address.
// ----------------------------------------------------------------------------
`default_nettype none

module mrf_cfg import mrf_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [31:0]           pwdata,
    output logic      [31:0]           prdata,
    output logic                       pready,
    output logic      [7:0]            o_slave_address
);

    logic [7:0] r_slave_address;
    logic       hit;

    assign hit = (paddr[CFG_ADDR_W-1:2] == REG_SLAVE_ADDR);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slave_address <= SLAVE_ADDR_RST;
        end else if (psel && penable && pwrite && hit) begin
            r_slave_address <= pwdata[7:0];
        end
    end

    assign prdata          = hit ? {24'h000000, r_slave_address} : 32'h0;
    assign pready          = 1'b1;
    assign o_slave_address = r_slave_address;

endmodule

`default_nettype wire

FILE: sv/mrf_plan.sv
// ----------------------------------------------------------------------------
// mrf_plan
// Takes request words, tracks the open write and registers a byte plan.
// ----------------------------------------------------------------------------
`default_nettype none

`include "modbus_rtu_request_framer_macros.svh"

module mrf_plan import mrf_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic [7:0] i_slave_address,
    mrf_req_if.sink         i_req,
    input  wire logic       i_take,
    output t_plan           o_plan,
    output logic            o_plan_vld
);

    t_plan      r_plan;
    t_plan      n_plan;
    logic       r_plan_vld;
    logic [6:0] r_words_left;
    logic [6:0] n_words_left;
    logic       r_pending;
    logic       n_pending;
    logic       n_emit;
    logic       accept;
    logic [6:0] cnt_sat;

    assign i_req.ready = !r_plan_vld || i_take;
    assign accept      = i_req.valid && i_req.ready;
    assign cnt_sat     = (i_req.reg_count > MAX_WRITE_WORDS) ? MAX_WRITE_WORDS
                                                             : i_req.reg_count;

    always_comb begin
        n_plan       = '0;
        n_emit       = 1'b0;
        n_words_left = r_words_left;
        n_pending    = r_pending;
        case (t_mode'(i_req.mode))
            MODE_READ: begin
                n_emit          = 1'b1;
                n_plan.head     = 1'b1;
                n_plan.data[0]  = i_slave_address;
                n_plan.data[1]  = i_req.function_code;
                n_plan.data[2]  = i_req.reg_address[15:8];
                n_plan.data[3]  = i_req.reg_address[7:0];
                n_plan.data[5]  = {1'b0, i_req.reg_count};
                n_plan.kind[6]  = SLOT_CRC_LO;
                n_plan.kind[7]  = SLOT_CRC_HI;
                n_plan.last     = PLAN_IDX_W'(7);
                n_words_left    = '0;
                n_pending       = 1'b0;
            end
            MODE_WRITE_HDR: begin
                if (i_req.reg_count != '0) begin
                    n_emit         = 1'b1;
                    n_plan.head    = 1'b1;
                    n_plan.data[0] = i_slave_address;
                    n_plan.data[1] = i_req.function_code;
                    n_plan.data[2] = i_req.reg_address[15:8];
                    n_plan.data[3] = i_req.reg_address[7:0];
                    n_plan.data[5] = {1'b0, cnt_sat};
                    n_plan.data[6] = {cnt_sat, 1'b0};
                    n_plan.last    = PLAN_IDX_W'(6);
                    n_words_left   = cnt_sat;
                    n_pending      = 1'b1;
                end
            end
            MODE_WRITE_DATA: begin
                if (r_pending) begin
                    n_emit         = 1'b1;
                    n_plan.data[0] = i_req.data_word[15:8];
                    n_plan.data[1] = i_req.data_word[7:0];
                    n_words_left   = r_words_left - 7'd1;
                    if (r_words_left == 7'd1) begin
                        // last word closes the frame
                        n_plan.kind[2] = SLOT_CRC_LO;
                        n_plan.kind[3] = SLOT_CRC_HI;
                        n_plan.last    = PLAN_IDX_W'(3);
                        n_pending      = 1'b0;
                    end else begin
                        n_plan.last    = PLAN_IDX_W'(1);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plan_vld   <= 1'b0;
            r_words_left <= '0;
            r_pending    <= 1'b0;
        end else if (accept) begin
            r_plan_vld   <= n_emit;
            r_words_left <= n_words_left;
            r_pending    <= n_pending;
        end else if (i_take) begin
            r_plan_vld   <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_plan <= n_plan;
        end
    end

    assign o_plan     = r_plan;
    assign o_plan_vld = r_plan_vld;

    `MRF_ASSERT(a_idle_no_words, !r_pending, r_words_left == 7'd0)
    `MRF_ASSERT(a_pending_has_words, r_pending, r_words_left != 7'd0)

endmodule

`default_nettype wire

FILE: sv/mrf_ser.sv
// ----------------------------------------------------------------------------
// mrf_ser
// Walks the byte plan one slot per cycle into the output register while the
// receiver is ready, and keeps the running CRC of the open frame.
// ----------------------------------------------------------------------------
`default_nettype none

`include "modbus_rtu_request_framer_macros.svh"

module mrf_ser import mrf_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_plan i_plan,
    input  wire logic  i_plan_vld,
    output logic       o_plan_take,
    mrf_byte_if.source o_tx
);

    logic [PLAN_IDX_W-1:0] r_idx;
    logic [15:0]           r_crc;
    logic [15:0]           n_crc;
    logic [15:0]           crc_base;
    logic                  r_out_vld;
    logic [7:0]            r_out_byte;
    logic                  r_out_start;
    logic                  r_out_end;
    logic                  r_out_last;
    logic [7:0]            sel_byte;
    t_slot_kind            sel_kind;
    logic                  ld;
    logic                  is_last;

    assign ld          = i_plan_vld && (!r_out_vld || o_tx.ready);
    assign is_last     = (r_idx == i_plan.last);
    assign o_plan_take = ld && is_last;
    assign sel_kind    = i_plan.kind[r_idx];
    // a frame's first byte restarts the CRC, dropping any abandoned frame
    assign crc_base    = (i_plan.head && r_idx == '0) ? CRC_INIT : r_crc;

    always_comb begin
        sel_byte = i_plan.data[r_idx];
        n_crc    = r_crc;
        case (sel_kind)
            SLOT_DATA: begin
                n_crc = crc16_byte(crc_base, i_plan.data[r_idx]);
            end
            SLOT_CRC_LO: begin
                sel_byte = r_crc[7:0];
            end
            SLOT_CRC_HI: begin
                sel_byte = r_crc[15:8];
                n_crc    = CRC_INIT;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx     <= '0;
            r_crc     <= CRC_INIT;
            r_out_vld <= 1'b0;
        end else begin
            if (ld) begin
                r_idx     <= is_last ? '0 : r_idx + PLAN_IDX_W'(1);
                r_crc     <= n_crc;
                r_out_vld <= 1'b1;
            end else if (o_tx.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld) begin
            r_out_byte  <= sel_byte;
            r_out_start <= i_plan.head && (r_idx == '0);
            r_out_end   <= (sel_kind == SLOT_CRC_HI);
            r_out_last  <= is_last;
        end
    end

    assign o_tx.valid       = r_out_vld;
    assign o_tx.tx_byte     = r_out_byte;
    assign o_tx.frame_start = r_out_start;
    assign o_tx.frame_end   = r_out_end;
    assign o_tx.run_last    = r_out_last;

    `MRF_ASSERT(a_end_is_last, o_tx.valid && o_tx.frame_end, o_tx.run_last)
    `MRF_ASSERT(a_idx_in_plan, i_plan_vld, r_idx <= i_plan.last)
    `MRF_ASSERT_NEXT(a_crc_rearm, ld && sel_kind == SLOT_CRC_HI, r_crc == CRC_INIT)

endmodule

`default_nettype wire

FILE: sv/modbus_rtu_request_framer.sv
// ----------------------------------------------------------------------------
// modbus_rtu_request_framer
// Modbus RTU master request framer: request words in, frame bytes out.
// ----------------------------------------------------------------------------
// Usage:
//   i_req takes request words (read request, write header, write data word)
//   with valid/ready. o_tx delivers frame bytes with valid/ready, one byte per
//   transfer, flagged frame_start on the slave address byte, frame_end on the CRC
//   high byte and run_last on the last byte caused by a request word.
//   The APB port holds the slave address (byte address 0, reset value 1);
//   write it only while the block is idle.
//   The first byte of a request is registered in the plan register and then
//   loaded into the output register, from which o_tx offers it. The output
//   register sends one byte per cycle while the receiver is ready; a read
//   request makes 8 bytes, a write header 7, a data word 2 (4 with the CRC).
//   The next request is taken in the cycle its predecessor's last byte
//   moves to the output register. Words that produce no byte are dropped at
//   their handshake and send nothing to the output register.
//   Reset clears the open write and both handshake stages and sets the CRC to CRC_INIT.
//   When the receiver stalls, the byte held in the output register stays and
//   the block stops taking requests once its plan register is full.
// ----------------------------------------------------------------------------
`default_nettype none

module modbus_rtu_request_framer import mrf_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    mrf_req_if.sink                    i_req,
    mrf_byte_if.source                 o_tx,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [31:0]           pwdata,
    output logic      [31:0]           prdata,
    output logic                       pready
);

    logic [7:0] slave_address;
    t_plan      plan;
    logic       plan_vld;
    logic       plan_take;

    mrf_cfg u_cfg (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .o_slave_address (slave_address)
    );

    mrf_plan u_plan (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_slave_address (slave_address),
        .i_req           (i_req),
        .i_take          (plan_take),
        .o_plan          (plan),
        .o_plan_vld      (plan_vld)
    );

    mrf_ser u_ser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_plan      (plan),
        .i_plan_vld  (plan_vld),
        .o_plan_take (plan_take),
        .o_tx        (o_tx)
    );

endmodule

`default_nettype wire

FILE: dv/tb_modbus_rtu_request_framer.sv
// ----------------------------------------------------------------------------
// tb_modbus_rtu_request_framer
// Self-checking bench for the Modbus RTU request framer. Drives read, write
// header and write data request words with bursty valid, stalls the byte
// channel on its own pattern, and checks every frame byte and its flags
// against an in-bench frame builder with its own CRC16.
// ----------------------------------------------------------------------------
module tb_modbus_rtu_request_framer;
    import mrf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          CLK_HALF_NS   = 6;
    localparam int          RESET_CYCLES  = 10;
    localparam int          SETTLE_CYCLES = 12;
    localparam longint      TIMEOUT_NS    = 5_000_000;
    localparam logic [1:0]  MODE_IGNORED  = 2'd3;
    localparam logic [CFG_ADDR_W-1:0] SLAVE_ADDR_OFFSET = CFG_ADDR_W'(4 * REG_SLAVE_ADDR);

    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  function_code;
        logic [15:0] reg_address;
        logic [6:0]  reg_count;
        logic [15:0] data_word;
    } t_request;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       frame_start;
        logic       frame_end;
        logic       run_last;
    } t_frame_byte;

    typedef enum {SINK_OPEN, SINK_RANDOM, SINK_PERIODIC, SINK_BURSTY} t_sink_style;

    class frame_byte_checker;
        logic [7:0]  station;
        logic [15:0] crc;
        logic [6:0]  words_due;
        bit          write_open;
        t_frame_byte pending_bytes[$];
        int unsigned failures, bytes_checked, framed_words;
        int unsigned reads_framed, writes_closed, writes_dropped, stations_used;

        function new();
            station    = SLAVE_ADDR_RST;
            crc        = CRC_INIT;
            words_due  = '0;
            write_open = 1'b0;
        endfunction

        function void set_station(logic [7:0] addr);
            station = addr;
            stations_used++;
        endfunction

        function int unsigned pending();
            return pending_bytes.size();
        endfunction

        // bitwise form of the reflected CRC16
        function logic [15:0] crc_next(logic [15:0] c, logic [7:0] b);
            logic fb;
            for (int i = 0; i < 8; i++) begin
                fb = c[0] ^ b[i];
                c  = c >> 1;
                if (fb) begin
                    c = c ^ CRC_POLY;
                end
            end
            return c;
        endfunction

        function void put_data(logic [7:0] b, logic start);
            crc = crc_next(crc, b);
            pending_bytes.push_back('{b, start, 1'b0, 1'b0});
        endfunction

        function void put_crc();
            pending_bytes.push_back('{crc[7:0], 1'b0, 1'b0, 1'b0});
            pending_bytes.push_back('{crc[15:8], 1'b0, 1'b1, 1'b0});
            crc = CRC_INIT;
        endfunction

        function void put_header(logic [7:0] code, logic [15:0] addr, logic [6:0] count);
            crc = CRC_INIT;
            put_data(station, 1'b1);
            put_data(code, 1'b0);
            put_data(addr[15:8], 1'b0);
            put_data(addr[7:0], 1'b0);
            put_data(8'h00, 1'b0);
            put_data({1'b0, count}, 1'b0);
        endfunction

        function void predict_frame_bytes(t_request r);
            int unsigned queued;
            logic [6:0]  n;
            t_frame_byte tail;
            queued = pending_bytes.size();
            n = r.reg_count;
            if (r.mode == MODE_READ) begin
                if (write_open) begin
                    writes_dropped++;
                end
                write_open = 1'b0;
                words_due  = '0;
                put_header(r.function_code, r.reg_address, n);
                put_crc();
                reads_framed++;
            end else if (r.mode == MODE_WRITE_HDR) begin
                // count zero is rejected and leaves any open write alone
                if (n != 0) begin
                    if (write_open) begin
                        writes_dropped++;
                    end
                    if (n > MAX_WRITE_WORDS) begin
                        n = MAX_WRITE_WORDS;
                    end
                    put_header(r.function_code, r.reg_address, n);
                    put_data({n, 1'b0}, 1'b0);
                    words_due  = n;
                    write_open = 1'b1;
                end
            end else if (r.mode == MODE_WRITE_DATA) begin
                if (write_open) begin
                    put_data(r.data_word[15:8], 1'b0);
                    put_data(r.data_word[7:0], 1'b0);
                    words_due = words_due - 7'd1;
                    if (words_due == 0) begin
                        put_crc();
                        write_open = 1'b0;
                        writes_closed++;
                    end
                end
            end
            // flag the last byte this word caused
            if (pending_bytes.size() > queued) begin
                tail = pending_bytes.pop_back();
                tail.run_last = 1'b1;
                pending_bytes.push_back(tail);
                framed_words++;
            end
        endfunction

        function void check_tx_byte(logic [7:0] b, logic fs, logic fe, logic rl);
            t_frame_byte want;
            if (pending_bytes.size() == 0) begin
                $error("unexpected frame byte 0x%02h", b);
                failures++;
                return;
            end
            want = pending_bytes.pop_front();
            bytes_checked++;
            if (b !== want.tx_byte) begin
                $error("tx_byte: expected 0x%02h, got 0x%02h", want.tx_byte, b);
                failures++;
            end
            if (fs !== want.frame_start) begin
                $error("frame_start: expected %0b, got %0b", want.frame_start, fs);
                failures++;
            end
            if (fe !== want.frame_end) begin
                $error("frame_end: expected %0b, got %0b", want.frame_end, fe);
                failures++;
            end
            if (rl !== want.run_last) begin
                $error("run_last: expected %0b, got %0b", want.run_last, rl);
                failures++;
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    mrf_req_if  req_ch();
    mrf_byte_if tx_ch();

    frame_byte_checker sb;
    int unsigned       burst_left;

    modbus_rtu_request_framer dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_ch),
        .o_tx    (tx_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        clk = 1'b0;
        forever #(CLK_HALF_NS) clk = ~clk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("Regression FAIL");
        $finish;
    end

    // byte channel receiver: stalls in a stall style that it picks anew at random
    initial begin
        t_sink_style style;
        int unsigned tick, stall_left;
        style      = SINK_OPEN;
        tick       = 0;
        stall_left = 0;
        tx_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (stall_left > 0) begin
                stall_left--;
                tx_ch.ready <= 1'b0;
            end else begin
                case (style)
                    SINK_OPEN:     tx_ch.ready <= 1'b1;
                    SINK_RANDOM:   tx_ch.ready <= ($urandom_range(0, 3) != 0);
                    SINK_PERIODIC: tx_ch.ready <= ((tick % 7) < 4);
                    default: begin
                        if ($urandom_range(0, 19) == 0) begin
                            stall_left = $urandom_range(4, 16);
                            tx_ch.ready <= 1'b0;
                        end else begin
                            tx_ch.ready <= 1'b1;
                        end
                    end
                endcase
            end
            tick++;
            if (tick % 300 == 0) begin
                style = t_sink_style'($urandom_range(0, 3));
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n && tx_ch.valid && tx_ch.ready) begin
            sb.check_tx_byte(tx_ch.tx_byte, tx_ch.frame_start, tx_ch.frame_end,
                             tx_ch.run_last);
        end
    end

    function automatic t_request make_request(logic [1:0] mode, logic [7:0] code,
                                              logic [15:0] addr, logic [6:0] count,
                                              logic [15:0] word);
        t_request r;
        r.mode          = mode;
        r.function_code = code;
        r.reg_address   = addr;
        r.reg_count     = count;
        r.data_word     = word;
        return r;
    endfunction

    function automatic t_request random_request(logic [1:0] mode, logic [6:0] count);
        return make_request(mode, 8'($urandom), 16'($urandom), count, 16'($urandom));
    endfunction

    // send one word; hold valid across a burst, drop it for a random gap between
    task automatic push_request(t_request r);
        if (burst_left == 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 8);
        end
        req_ch.valid         <= 1'b1;
        req_ch.mode          <= r.mode;
        req_ch.function_code <= r.function_code;
        req_ch.reg_address   <= r.reg_address;
        req_ch.reg_count     <= r.reg_count;
        req_ch.data_word     <= r.data_word;
        do @(posedge clk); while (!req_ch.ready);
        sb.predict_frame_bytes(r);
        burst_left--;
    endtask

    task automatic send_write(logic [6:0] count, int unsigned words);
        push_request(random_request(MODE_WRITE_HDR, count));
        repeat (words) push_request(random_request(MODE_WRITE_DATA, 7'($urandom)));
    endtask

    task automatic drain_frames();
        req_ch.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_slave_address(logic [7:0] addr);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= SLAVE_ADDR_OFFSET;
        pwdata  <= {24'h0, addr};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_station(addr);
    endtask

    task automatic run_traffic(int unsigned target);
        int unsigned pick, count;
        while (sb.framed_words < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                count = $urandom_range(1, 8);
                send_write(7'(count), count);
            end else if (pick < 70) begin
                push_request(random_request(MODE_READ, 7'($urandom_range(0, 127))));
            end else if (pick < 85) begin
                // abandon partway: a later read or a header with a non-zero count cuts it off
                count = $urandom_range(2, 8);
                send_write(7'(count), $urandom_range(0, count - 1));
            end else begin
                case ($urandom_range(0, 2))
                    0:       push_request(random_request(MODE_IGNORED, 7'($urandom)));
                    1:       push_request(random_request(MODE_WRITE_DATA, 7'($urandom)));
                    default: push_request(random_request(MODE_WRITE_HDR, 7'd0));
                endcase
            end
        end
    endtask

    initial begin
        sb         = new();
        burst_left = 0;
        rst_n                <= 1'b0;
        psel                 <= 1'b0;
        penable              <= 1'b0;
        pwrite               <= 1'b0;
        paddr                <= '0;
        pwdata               <= '0;
        req_ch.valid         <= 1'b0;
        req_ch.mode          <= MODE_READ;
        req_ch.function_code <= '0;
        req_ch.reg_address   <= '0;
        req_ch.reg_count     <= '0;
        req_ch.data_word     <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part at the reset slave address
        push_request(make_request(MODE_READ, 8'h03, 16'h0000, 7'd0, 16'h0000));
        push_request(make_request(MODE_READ, 8'hFF, 16'hFFFF, 7'd127, 16'hFFFF));
        push_request(make_request(MODE_READ, 8'h00, 16'h8001, 7'd125, 16'h0000));
        push_request(make_request(MODE_IGNORED, 8'hFF, 16'hFFFF, 7'h7F, 16'hFFFF));
        push_request(make_request(MODE_WRITE_DATA, 8'h10, 16'h0001, 7'd1, 16'hFFFF));
        push_request(make_request(MODE_WRITE_HDR, 8'h10, 16'h0010, 7'd0, 16'h0000));
        push_request(make_request(MODE_WRITE_HDR, 8'h10, 16'hA55A, 7'd2, 16'h0000));
        push_request(make_request(MODE_WRITE_DATA, 8'h00, 16'h0000, 7'd0, 16'hFFFF));
        push_request(make_request(MODE_WRITE_DATA, 8'h00, 16'h0000, 7'd0, 16'h0000));
        push_request(make_request(MODE_WRITE_DATA, 8'h00, 16'h0000, 7'd0, 16'h1234));
        push_request(make_request(MODE_WRITE_HDR, 8'h10, 16'h0100, 7'd127, 16'h0000));
        push_request(make_request(MODE_WRITE_DATA, 8'h00, 16'h0000, 7'd0, 16'h5AA5));
        push_request(make_request(MODE_WRITE_HDR, 8'h06, 16'h00FF, 7'd1, 16'h0000));
        push_request(make_request(MODE_WRITE_DATA, 8'h00, 16'h0000, 7'd0, 16'h8001));
        push_request(make_request(MODE_WRITE_HDR, 8'h10, 16'hFF00, 7'd124, 16'h0000));
        push_request(make_request(MODE_READ, 8'h04, 16'h1111, 7'd1, 16'h0000));
        push_request(make_request(MODE_WRITE_HDR, 8'h00, 16'h0000, 7'd1, 16'h0000));
        push_request(make_request(MODE_WRITE_DATA, 8'h00, 16'h0000, 7'd0, 16'h0000));
        push_request(make_request(MODE_WRITE_HDR, 8'h10, 16'h7FFE, 7'd64, 16'h0000));
        push_request(make_request(MODE_WRITE_DATA, 8'h00, 16'h0000, 7'd0, 16'hC3C3));
        // ignored and rejected words must leave the open write intact
        push_request(make_request(MODE_IGNORED, 8'h00, 16'h0000, 7'd0, 16'h0000));
        push_request(make_request(MODE_WRITE_HDR, 8'h10, 16'h0000, 7'd0, 16'h0000));
        push_request(make_request(MODE_WRITE_DATA, 8'h00, 16'h0000, 7'd0, 16'h3C3C));
        push_request(make_request(MODE_READ, 8'h03, 16'h4000, 7'd64, 16'h0000));
        drain_frames();

        write_slave_address(8'h00);
        // one full write at the saturated count
        send_write(7'($urandom_range(123, 127)), MAX_WRITE_WORDS);
        run_traffic(170);
        drain_frames();

        write_slave_address(8'hFF);
        run_traffic(230);
        drain_frames();

        write_slave_address(8'($urandom));
        run_traffic(280);
        drain_frames();

        $display("Covered %0d words at %0d slave addresses: %0d reads, %0d writes, %0d cut off",
                 sb.framed_words, sb.stations_used + 1, sb.reads_framed, sb.writes_closed,
                 sb.writes_dropped);
        $display("Checked %0d frame bytes, %0d mismatches", sb.bytes_checked, sb.failures);
        if (sb.failures == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+sv
sv/mrf_pkg.sv
sv/mrf_ifs.sv
sv/mrf_cfg.sv
sv/mrf_plan.sv
sv/mrf_ser.sv
sv/modbus_rtu_request_framer.sv
dv/tb_modbus_rtu_request_framer.sv
